// ===== rtl/core/oldr_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Shared codes, widths and control types of the ordered list unit.
// ----------------------------------------------------------------------------
package oldr_pkg;

  localparam int VALUE_W  = 16;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_LIST_FWD  = 3'd3,
    OP_LIST_BWD  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5
  } status_t;

  // What every cell loads in a cycle.
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_FROM_LOWER,
    MODE_FROM_HIGHER,
    MODE_WRITE_SEL
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       load_front;  // cell 0 takes the inserted value from below
    logic       drop_ring;   // ring closes over all cells but the last
  } cell_ctl_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_REMOVE,
    SEQ_LIST_FWD,
    SEQ_LIST_BWD
  } seq_state_t;

endpackage

// ===== rtl/core/oldr_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation and its value or key from source to sink.
// ----------------------------------------------------------------------------
interface oldr_req_if;
  logic                          valid;
  logic                          ready;
  logic [oldr_pkg::OP_W-1:0]     operation;
  logic [oldr_pkg::VALUE_W-1:0]  coach_number;

  modport source (output valid, output operation, output coach_number, input ready);
  modport sink   (input valid, input operation, input coach_number, output ready);
endinterface

// ===== rtl/core/oldr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Carries one status result with its value and last marker.
// ----------------------------------------------------------------------------
interface oldr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [oldr_pkg::STATUS_W-1:0]  status;
  logic [oldr_pkg::VALUE_W-1:0]   coach_value;
  logic                           last;

  modport source (output valid, output status, output coach_value, output last, input ready);
  modport sink   (input valid, input status, input coach_value, input last, output ready);
endinterface

// ===== rtl/core/oldr_cell.sv =====
// ----------------------------------------------------------------------------
// List cell
// One entry of the list; loads from a neighbour, the insert value or holds.
// ----------------------------------------------------------------------------
module oldr_cell (
  input  logic                          clk,
  input  oldr_pkg::cell_ctl_t           ctl,
  input  logic                          sel,
  input  logic [oldr_pkg::VALUE_W-1:0]  lower,
  input  logic [oldr_pkg::VALUE_W-1:0]  higher,
  input  logic [oldr_pkg::VALUE_W-1:0]  ins,
  output logic [oldr_pkg::VALUE_W-1:0]  value
);
  import oldr_pkg::*;

  logic [VALUE_W-1:0] value_next;

  always_comb begin
    case (ctl.mode)
      MODE_HOLD:        value_next = value;
      MODE_FROM_LOWER:  value_next = lower;
      MODE_FROM_HIGHER: value_next = higher;
      MODE_WRITE_SEL:   value_next = sel ? ins : value;
      default:          value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== rtl/core/oldr_ctrl.sv =====
// ----------------------------------------------------------------------------
// List sequencer
// Decodes requests, steps the cell ring and drives the response register.
// ----------------------------------------------------------------------------
module oldr_ctrl #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  oldr_req_if.sink                      req,
  oldr_rsp_if.source                    rsp,
  input  logic [oldr_pkg::VALUE_W-1:0]  head,
  input  logic [oldr_pkg::VALUE_W-1:0]  tail,
  output oldr_pkg::cell_ctl_t           ctl,
  output logic [$clog2(CAPACITY+1)-1:0] count
);
  import oldr_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);
  localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  seq_state_t         state, state_next;
  logic [CW-1:0]      count_next;
  logic [SW-1:0]      step, step_next;
  logic [VALUE_W-1:0] key, key_next;
  logic               found, found_next;

  logic               out_valid;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;

  logic               out_free;
  logic               in_take;
  logic [CW-1:0]      step_w;
  logic               match;
  logic               fwd_emit, bwd_emit;
  logic               stall;
  logic               step_done;

  logic               emit;
  status_t            emit_status;
  logic [VALUE_W-1:0] emit_value;
  logic               emit_last;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == SEQ_IDLE) && out_free;
  assign in_take   = req.valid && req.ready;

  assign step_w    = CW'(step);
  assign match     = !found && (step_w < count) && (head == key);
  assign fwd_emit  = step_w < count;
  assign bwd_emit  = step_w >= (FULL_COUNT - count);

  // Hold the ring whenever a result is due but the response slot is taken.
  always_comb begin
    case (state)
      SEQ_REMOVE:   stall = (step == LAST_STEP) && !out_free;
      SEQ_LIST_FWD: stall = fwd_emit && !out_free;
      SEQ_LIST_BWD: stall = bwd_emit && !out_free;
      default:      stall = 1'b0;
    endcase
  end

  assign step_done = (step == LAST_STEP) && !stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (in_take && count != '0) begin
          case (req.operation)
            OP_REMOVE:   state_next = SEQ_REMOVE;
            OP_LIST_FWD: state_next = SEQ_LIST_FWD;
            OP_LIST_BWD: state_next = SEQ_LIST_BWD;
            default:     state_next = SEQ_IDLE;
          endcase
        end
      end
      SEQ_REMOVE, SEQ_LIST_FWD, SEQ_LIST_BWD: begin
        if (step_done) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Cell control, bookkeeping and results.
  always_comb begin
    ctl         = '{mode: MODE_HOLD, load_front: 1'b0, drop_ring: found};
    count_next  = count;
    step_next   = step;
    key_next    = key;
    found_next  = found;
    emit        = 1'b0;
    emit_status = ST_ADDED;
    emit_value  = req.coach_number;
    emit_last   = 1'b1;
    case (state)
      SEQ_IDLE: begin
        if (in_take) begin
          step_next  = '0;
          found_next = 1'b0;
          key_next   = req.coach_number;
          case (req.operation)
            OP_INS_FRONT, OP_INS_BACK: begin
              emit = 1'b1;
              if (count == FULL_COUNT) begin
                emit_status = ST_FULL;
              end else begin
                ctl.load_front = (req.operation == OP_INS_FRONT);
                ctl.mode       = (req.operation == OP_INS_FRONT) ? MODE_FROM_LOWER
                                                                 : MODE_WRITE_SEL;
                count_next     = count + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end
            end
            OP_LIST_FWD, OP_LIST_BWD: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
                emit_value  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_REMOVE: begin
        if (!stall) begin
          // Rotate left; a match leaves the ring and it closes one cell shorter.
          ctl.mode  = MODE_FROM_HIGHER;
          step_next = step + 1'b1;
          if (match) found_next = 1'b1;
          if (step == LAST_STEP) begin
            emit        = 1'b1;
            emit_value  = key;
            emit_status = (found || match) ? ST_REMOVED : ST_NOT_FOUND;
            if (found || match) count_next = count - 1'b1;
          end
        end
      end
      SEQ_LIST_FWD: begin
        if (!stall) begin
          ctl.mode    = MODE_FROM_HIGHER;
          step_next   = step + 1'b1;
          emit        = fwd_emit;
          emit_status = ST_LISTED;
          emit_value  = head;
          emit_last   = (step_w == count - 1'b1);
        end
      end
      SEQ_LIST_BWD: begin
        if (!stall) begin
          ctl.mode    = MODE_FROM_LOWER;
          step_next   = step + 1'b1;
          emit        = bwd_emit;
          emit_status = ST_LISTED;
          emit_value  = tail;
          emit_last   = (step == LAST_STEP);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      count     <= '0;
      step      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      found <= found_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (emit) begin
      out_status <= emit_status;
      out_value  <= emit_value;
      out_last   <= emit_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.coach_value = out_value;
  assign rsp.last        = out_last;

endmodule

// ===== rtl/core/ordered_list_deque_remove_by_key_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered list unit
// Bounded front-to-rear list of 16-bit values kept in a ring of cells.
// ----------------------------------------------------------------------------
// Use:
//   req carries an operation (insert front, insert back, remove by key,
//   list forward, list backward) and a value or key. rsp returns the
//   results: one status for an insert or a remove, one listed entry per
//   held value for a listing (last set on the final one), or a single
//   empty status. Unused operation codes give no result.
// Timing:
//   An insert, a full insert and any remove or listing on an empty list
//   give their result in the response register in the cycle after the
//   transfer. Remove and listings rotate the ring of CAPACITY cells once a
//   cycle, unless a held response stalls it, for one full turn after the
//   transfer; the next request is taken only once the turn is done, and the
//   ring ends in its original order (less the removed entry).
// Reset:
//   Synchronous; clears the fill count, the sequencer and the response
//   valid. Cell contents are not cleared: only cells below the count are
//   ever reported.
// Stalls:
//   A held response freezes the ring until the result is taken; nothing
//   is lost or repeated.
// ----------------------------------------------------------------------------
module ordered_list_deque_remove_by_key_unit #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  oldr_req_if.sink   req,
  oldr_rsp_if.source rsp
);
  import oldr_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cell_ctl_t          ctl;
  logic [CW-1:0]      count;
  logic [VALUE_W-1:0] cells [CAPACITY];

  // Sequencer: decode, step count and response register.
  oldr_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .head  (cells[0]),
    .tail  (cells[CAPACITY-1]),
    .ctl   (ctl),
    .count (count)
  );

  // Ring of cells. Cell 0 is the front. Lower neighbour feeds a right
  // rotation or an insert at the front; higher neighbour feeds a left
  // rotation. After a removal the ring closes over all cells but the last.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] lower;
    logic [VALUE_W-1:0] higher;
    logic               sel;

    if (i == 0) begin : g_lo_front
      assign lower = ctl.load_front ? req.coach_number : cells[CAPACITY-1];
    end else begin : g_lo_mid
      assign lower = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_last
      // Hold the spare cell once the ring has dropped it.
      assign higher = ctl.drop_ring ? cells[CAPACITY-1] : cells[0];
    end else if (i == CAPACITY - 2) begin : g_hi_wrap
      assign higher = ctl.drop_ring ? cells[0] : cells[CAPACITY-1];
    end else begin : g_hi_mid
      assign higher = cells[i+1];
    end

    // Insert at the back writes the cell just past the last entry.
    assign sel = (count == CW'(i));

    oldr_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .sel    (sel),
      .lower  (lower),
      .higher (higher),
      .ins    (req.coach_number),
      .value  (cells[i])
    );
  end

endmodule

// ===== tb/tb_ordered_list_deque_remove_by_key_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list unit testbench
// Sends insert, remove-by-key and listing requests with random gaps and
// stalls on both channels. A tracker keeps its own copy of the list, works
// out the results each accepted request should give, and checks the
// returned results in order.
// ----------------------------------------------------------------------------
module tb_ordered_list_deque_remove_by_key_unit;
  import oldr_pkg::*;

  localparam int CAPACITY      = 32;
  localparam int CLK_PERIOD    = 10;
  localparam int RANDOM_ITEMS  = 250;        // random requests that the block acts on
  localparam int TAIL_ITEMS    = 40;         // last stretch runs with no idling
  localparam int HOLD_AT       = 90;         // random request count that starts the long hold
  localparam int DRAIN_AT      = 160;        // random request count that starts the full drain
  localparam int LONG_HOLD     = 300;        // cycles the result side holds off
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int TIMEOUT_NS    = 8_000_000;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic               last;
  } coach_result_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

  // --------------------------------------------------------------------------
  // List tracker: own copy of the list (index 0 is the front) and the queue
  // of results still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class coach_list_tracker;
    logic [VALUE_W-1:0] coaches[$];
    coach_result_t      owed[$];
    int errors;
    int n_results;
    int n_inserts;
    int n_full_drops;
    int n_removes;
    int n_hits;
    int n_lists;
    int n_ignored;
    int peak_fill;

    function void owe(status_t st, logic [VALUE_W-1:0] v, logic l);
      coach_result_t r;
      r.status = st;
      r.value  = v;
      r.last   = l;
      owed.push_back(r);
    endfunction

    // Apply one accepted request to the list and queue what it gives.
    function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v);
      int i;
      int hit;
      int fill;
      hit  = -1;
      fill = coaches.size();
      case (op)
        OP_INS_FRONT, OP_INS_BACK: begin
          n_inserts++;
          if (fill >= CAPACITY) begin
            n_full_drops++;
            owe(ST_FULL, v, 1'b1);
          end else begin
            if (op == OP_INS_FRONT) coaches.push_front(v);
            else coaches.push_back(v);
            owe(ST_ADDED, v, 1'b1);
            if (coaches.size() > peak_fill) peak_fill = coaches.size();
          end
        end
        OP_REMOVE: begin
          n_removes++;
          if (fill == 0) begin
            owe(ST_EMPTY, v, 1'b1);
          end else begin
            for (i = 0; i < fill; i++)
              if (hit < 0 && coaches[i] == v) hit = i;
            if (hit < 0) begin
              owe(ST_NOT_FOUND, v, 1'b1);
            end else begin
              n_hits++;
              coaches.delete(hit);
              owe(ST_REMOVED, v, 1'b1);
            end
          end
        end
        OP_LIST_FWD, OP_LIST_BWD: begin
          n_lists++;
          if (fill == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++)
              owe(ST_LISTED, (op == OP_LIST_FWD) ? coaches[i] : coaches[fill - 1 - i],
                  (i == fill - 1));
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    // Compare one returned result with the oldest owed one.
    function void check_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] v, logic l);
      coach_result_t want;
      n_results++;
      if (owed.size() == 0) begin
        errors++;
        $error("unexpected result: status %0d coach_value %0h last %0b", st, v, l);
        return;
      end
      want = owed.pop_front();
      if (st !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, st);
      end
      if (v !== want.value) begin
        errors++;
        $error("coach_value: expected %0h, got %0h", want.value, v);
      end
      if (l !== want.last) begin
        errors++;
        $error("last: expected %0b, got %0b", want.last, l);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  oldr_req_if req ();
  oldr_rsp_if rsp ();

  coach_list_tracker tracker;

  bit tail_calm = 1'b0;   // set for the closing stretch: no gaps, no stalls
  bit hold_rsp  = 1'b0;   // raised once by the request side to start the long hold

  ordered_list_deque_remove_by_key_unit #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: sample every transfer at the rising edge and check it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      tracker.check_result(rsp.status, rsp.coach_value, rsp.last);
  end

  // Drive ready at the falling edge. Stall in bursts of random length, with
  // calm stretches in between; hold off for a long stretch once on request
  // so that the block backs up and stalls its input.
  initial begin : rsp_side
    int gap;
    int calm;
    bit held;
    calm      = 0;
    held      = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp && !held) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (tail_calm || calm > 0) begin
        rsp.ready <= 1'b1;
        if (calm > 0) calm--;
      end else if ($urandom_range(0, 49) == 0) begin
        calm = $urandom_range(30, 120);
        rsp.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        rsp.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Present one request at the falling edge and hold it until the transfer.
  // Valid is left high: the caller either presents the next request or
  // drops valid at the very next falling edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
    @(negedge clk);
    req.valid        <= 1'b1;
    req.operation    <= op;
    req.coach_number <= v;
    do @(posedge clk); while (!req.ready);
    tracker.note_request(op, v);
  endtask

  // Drop valid for the given number of cycles.
  task automatic idle_request(input int cycles);
    @(negedge clk);
    req.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Pause until the block has returned everything owed.
  task automatic wait_drained();
    idle_request(1);
    while (tracker.owed.size() != 0) @(negedge clk);
  endtask

  // Values lean towards the extremes and a small pool, so that duplicates
  // and repeated keys turn up often.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return VALUE_W'($urandom_range(0, 7));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Mostly a key that is held somewhere in the list, otherwise any value.
  function automatic logic [VALUE_W-1:0] pick_key();
    int fill;
    fill = tracker.coaches.size();
    if (fill > 0 && $urandom_range(0, 9) < 8)
      return tracker.coaches[$urandom_range(0, fill - 1)];
    return pick_value();
  endfunction

  // One random request shaped by the traffic mix; counted is low for an
  // unused operation code, which the block ignores.
  task automatic send_random(input traffic_mix_t mix, input int idle_pct, output bit counted);
    int roll;
    int ins_lim;
    int rem_lim;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] v;
    case (mix)
      MIX_GROW:   begin ins_lim = 70; rem_lim = 82; end
      MIX_SHRINK: begin ins_lim = 20; rem_lim = 75; end
      default:    begin ins_lim = 40; rem_lim = 72; end
    endcase
    roll    = $urandom_range(0, 99);
    counted = 1'b1;
    if (roll < ins_lim) begin
      op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
      v  = pick_value();
    end else if (roll < rem_lim) begin
      op = OP_REMOVE;
      v  = pick_key();
    end else if (roll < 95) begin
      op = $urandom_range(0, 1) ? OP_LIST_BWD : OP_LIST_FWD;
      v  = VALUE_W'($urandom);
    end else begin
      op      = OP_W'($urandom_range(OP_LIST_BWD + 1, (1 << OP_W) - 1));
      v       = VALUE_W'($urandom);
      counted = 1'b0;
    end
    if (!tail_calm && $urandom_range(0, 99) < idle_pct)
      idle_request($urandom_range(1, 13));
    send_request(op, v);
  endtask

  initial begin : stimulus
    int           acted;
    int           k;
    int           seg_len;
    int           idle_pct;
    bit           counted;
    bit           hold_done;
    bit           drain_done;
    traffic_mix_t mix;

    tracker          = new();
    acted            = 0;
    hold_done        = 1'b0;
    drain_done       = 1'b0;
    req.valid        = 1'b0;
    req.operation    = OP_INS_FRONT;
    req.coach_number = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list cases, extremes, duplicates, unused codes.
    send_request(OP_LIST_FWD, 16'h1234);    // listing an empty list
    send_request(OP_LIST_BWD, 16'hFFFF);
    send_request(OP_REMOVE, 16'hFFFF);      // remove from an empty list
    send_request(OP_INS_FRONT, 16'h0000);
    send_request(OP_INS_BACK, 16'hFFFF);
    send_request(OP_INS_FRONT, 16'h8000);
    send_request(OP_INS_BACK, 16'h0001);
    send_request(OP_INS_FRONT, 16'h0001);   // duplicate value
    send_request(OP_LIST_FWD, 16'h0000);
    send_request(OP_LIST_BWD, 16'hFFFF);
    send_request(OP_REMOVE, 16'h5A5A);      // key not present
    send_request(OP_REMOVE, 16'h0001);      // only the frontmost match goes
    send_request(OP_LIST_FWD, 16'h7FFF);
    idle_request(7);
    send_request(OP_W'(OP_LIST_BWD + 1), 16'hAAAA);  // unused codes: no result
    send_request(OP_W'(OP_LIST_BWD + 2), 16'h5555);
    send_request(OP_W'((1 << OP_W) - 1), 16'hFFFF);
    send_request(OP_REMOVE, 16'hFFFF);      // entry next to the rear
    send_request(OP_REMOVE, 16'h0000);
    send_request(OP_REMOVE, 16'h8000);
    send_request(OP_REMOVE, 16'h0001);      // list empty again
    send_request(OP_LIST_BWD, 16'h0000);
    wait_drained();

    // Fill to capacity, push a few inserts past it, then list it whole.
    while (tracker.coaches.size() < CAPACITY) begin
      if ($urandom_range(0, 99) < 15) idle_request($urandom_range(1, 13));
      send_request($urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT, pick_value());
      acted++;
    end
    send_request(OP_INS_FRONT, 16'hFFFF);
    send_request(OP_INS_BACK, 16'h0000);
    send_request(OP_INS_BACK, pick_value());
    send_request(OP_LIST_FWD, VALUE_W'($urandom));
    send_request(OP_LIST_BWD, VALUE_W'($urandom));
    acted += 5;

    // Random segments, each with its own traffic mix and gap rate.
    while (acted < RANDOM_ITEMS) begin
      mix = traffic_mix_t'($urandom_range(0, 2));
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      seg_len = $urandom_range(15, 40);
      for (k = 0; k < seg_len && acted < RANDOM_ITEMS; k++) begin
        if (acted >= RANDOM_ITEMS - TAIL_ITEMS) tail_calm = 1'b1;
        // Hold off the result side while requests keep coming.
        if (acted >= HOLD_AT && !hold_done) begin
          hold_rsp  = 1'b1;
          hold_done = 1'b1;
        end
        // Let the block run dry once before carrying on.
        if (acted >= DRAIN_AT && !drain_done) begin
          wait_drained();
          drain_done = 1'b1;
        end
        send_random(mix, idle_pct, counted);
        if (counted) acted++;
      end
    end

    // Wind down: drop valid, collect what is owed, then watch for strays.
    idle_request(1);
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts (%0d dropped as full), %0d removes (%0d matched), %0d listings and %0d unused codes.",
             tracker.n_inserts, tracker.n_full_drops, tracker.n_removes, tracker.n_hits,
             tracker.n_lists, tracker.n_ignored);
    $display("%0d results checked; fill reached %0d of %0d entries.",
             tracker.n_results, tracker.peak_fill, CAPACITY);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
